### hdl/accel_fifo_sample_decoder_assert.svh
// Assertion macros for the accelerometer FIFO sample decoder.
`ifndef ACCEL_FIFO_SAMPLE_DECODER_ASSERT_SVH
`define ACCEL_FIFO_SAMPLE_DECODER_ASSERT_SVH

// Same-cycle implication, checked on i_clk with i_rst_n low as reset.
`define AFSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk with i_rst_n low as reset.
`define AFSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/afsd_pkg.sv
// Shared types and constants for the accelerometer FIFO sample decoder.
package afsd_pkg;

    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 14;
    localparam int COUNT_W     = 10;
    localparam int RANGE_W     = 2;
    localparam int PHASE_W     = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [RANGE_W-1:0] RANGE_2G = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_4G = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_8G = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        t_axis            axis;
        logic             burst;
        logic [RAW_W-1:0] raw;
    } t_entry;

endpackage

### hdl/afsd_byte_if.sv
// Request channel carrying raw FIFO bytes.
interface afsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] fifo_byte;
    logic       burst_start;

    modport source(output valid, output fifo_byte, output burst_start, input ready);
    modport sink(input valid, input fifo_byte, input burst_start, output ready);
endinterface

### hdl/afsd_set_if.sv
// Request channel carrying decoded X/Y/Z sets.
interface afsd_set_if;
    logic              valid;
    logic              ready;
    logic signed [13:0] x_mg;
    logic signed [13:0] y_mg;
    logic signed [13:0] z_mg;
    logic              set_valid;
    logic [9:0]        valid_sets;

    modport source(output valid, output x_mg, output y_mg, output z_mg,
                   output set_valid, output valid_sets, input ready);
    modport sink(input valid, input x_mg, input y_mg, input z_mg,
                 input set_valid, input valid_sets, output ready);
endinterface

### hdl/accel_fifo_sample_decoder.sv
// Top level of the accelerometer FIFO sample decoder.
//
// i_byte takes one raw FIFO byte per request, high byte of each entry first;
// burst_start on a byte restarts framing and clears the valid-set tracking.
// Every sixth byte of a burst yields one X/Y/Z set on o_set, scaled to
// milli-g by the range register (i_cfg_we / i_cfg_wdata: 0 = 2g, 1 = 4g,
// 2 = 8g, 3 treated as 2g), with a set_valid flag and a saturating count.
// Throughput: one byte per cycle sustained while o_set is not stalled. The
// framer pushes one entry every two bytes into a short queue; the decoder
// drains one entry a cycle unless a Z entry waits for the output register.
// Each set passes through the queue register, then the output register.
// When o_set stalls, the decoder holds the Z entry, the queue fills, and
// i_byte.ready drops on the next low byte; high bytes are still taken.
// Reset (i_rst_n low, synchronous) empties the queue and output register,
// sets framing to the first byte and the range to 2g.
module accel_fifo_sample_decoder #(
    parameter int QUEUE_DEPTH = afsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [afsd_pkg::RANGE_W-1:0] i_cfg_wdata,
    afsd_byte_if.sink                    i_byte,
    afsd_set_if.source                   o_set
);
    import afsd_pkg::*;

    logic   w_push_valid, w_push_ready;
    t_entry w_push_data;
    logic   w_pop_valid, w_pop_ready;
    t_entry w_pop_data;

    afsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    afsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    afsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_set       (o_set)
    );

`include "accel_fifo_sample_decoder_assert.svh"

    `AFSD_ASSERT_NOW(a_push_has_room, w_push_valid, w_push_ready,
        "framer pushed an entry into a full queue")
    `AFSD_ASSERT_NEXT(a_set_from_z, w_pop_valid && w_pop_ready && w_pop_data.axis == AXIS_Z,
        o_set.valid, "Z entry decoded but no set presented")
    `AFSD_ASSERT_NOW(a_valid_counted, o_set.valid && o_set.set_valid,
        o_set.valid_sets != '0, "valid set reported with zero count")
endmodule

### hdl/afsd_front.sv
// Byte framing: pairs FIFO bytes into tagged axis entries.
module afsd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    afsd_byte_if.sink             i_byte,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output afsd_pkg::t_entry      o_push_data
);
    import afsd_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_hi;
    logic               r_burst;
    logic [PHASE_W-1:0] eff_phase;
    logic               accept;

    assign i_byte.ready = !r_phase[0] || i_push_ready;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        eff_phase = r_phase;
        if (i_byte.burst_start || r_phase > PHASE_W'(5)) begin
            eff_phase = '0;
        end
        n_phase = r_phase;
        if (accept) begin
            n_phase = (eff_phase == PHASE_W'(5)) ? '0 : eff_phase + PHASE_W'(1);
        end
    end

    assign o_push_valid      = accept && eff_phase[0];
    assign o_push_data.axis  = t_axis'(eff_phase[2:1]);
    assign o_push_data.burst = r_burst && (eff_phase[2:1] == 2'd0);
    assign o_push_data.raw   = {r_hi[RAW_W-BYTE_W-1:0], i_byte.fifo_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !eff_phase[0]) begin
            r_hi    <= i_byte.fifo_byte;
            r_burst <= i_byte.burst_start;
        end
    end
endmodule

### hdl/afsd_queue.sv
// Short entry queue between framing and decode.
module afsd_queue #(
    parameter int DEPTH = afsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  afsd_pkg::t_entry i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output afsd_pkg::t_entry o_pop_data
);
    import afsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end
endmodule

### hdl/afsd_back.sv
// Entry decode, scaling, set assembly and valid-set tracking.
module afsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [afsd_pkg::RANGE_W-1:0]  i_cfg_wdata,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  afsd_pkg::t_entry              i_pop_data,
    afsd_set_if.source                    o_set
);
    import afsd_pkg::*;

    logic [RANGE_W-1:0] r_range;
    logic [RAW_W-1:0]   r_hx, r_hy;
    logic               r_zero_seen;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [RAW_W-1:0]   r_ox, r_oy, r_oz;
    logic               r_oset_valid;
    logic [COUNT_W-1:0] r_ocount;

    logic               slot_free, pop, is_z;
    logic               neg;
    logic [RAW_W-1:0]   mag, dec;
    logic               zero_cur, zero_now;
    logic [COUNT_W-1:0] count_cur, count_now;

    assign slot_free   = !r_out_valid || o_set.ready;
    assign is_z        = i_pop_data.axis == AXIS_Z;
    assign o_pop_ready = !is_z || slot_free;
    assign pop         = i_pop_valid && o_pop_ready;

    // sign-magnitude shift gives truncation toward zero
    always_comb begin
        neg = i_pop_data.raw[RAW_W-1];
        mag = neg ? (~i_pop_data.raw + RAW_W'(1)) : i_pop_data.raw;
        case (r_range)
            RANGE_4G: mag = mag >> 1;
            RANGE_8G: mag = mag;
            default:  mag = mag >> 2;
        endcase
        dec = neg ? (RAW_W'(0) - mag) : mag;

        zero_cur  = i_pop_data.burst ? 1'b0 : r_zero_seen;
        count_cur = i_pop_data.burst ? '0 : r_count;
        zero_now  = zero_cur || (r_hx == '0 && r_hy == '0 && dec == '0);
        count_now = count_cur;
        if (!zero_now && count_cur != COUNT_MAX) begin
            count_now = count_cur + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range     <= RANGE_2G;
            r_zero_seen <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_range <= i_cfg_wdata;
            end
            if (pop) begin
                r_zero_seen <= is_z ? zero_now : zero_cur;
                r_count     <= is_z ? count_now : count_cur;
            end
            if (pop && is_z) begin
                r_out_valid <= 1'b1;
            end else if (o_set.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx <= '0;
            r_hy <= '0;
        end else if (pop) begin
            case (i_pop_data.axis)
                AXIS_X:  r_hx <= dec;
                AXIS_Y:  r_hy <= dec;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && is_z) begin
            r_ox         <= r_hx;
            r_oy         <= r_hy;
            r_oz         <= dec;
            r_oset_valid <= !zero_now;
            r_ocount     <= count_now;
        end
    end

    assign o_set.valid      = r_out_valid;
    assign o_set.x_mg       = $signed(r_ox);
    assign o_set.y_mg       = $signed(r_oy);
    assign o_set.z_mg       = $signed(r_oz);
    assign o_set.set_valid  = r_oset_valid;
    assign o_set.valid_sets = r_ocount;
endmodule

### tb/tb_top.sv
// Testbench for accel_fifo_sample_decoder: byte stream in, predicted X/Y/Z sets checked out.
`timescale 1ns / 1ps

module tb_top;
    import afsd_pkg::*;

    localparam logic [RANGE_W-1:0] RANGE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic signed [RAW_W-1:0] x;
        logic signed [RAW_W-1:0] y;
        logic signed [RAW_W-1:0] z;
        logic                    ok;
        logic [COUNT_W-1:0]      cnt;
    } t_mg_set;

    typedef struct {
        logic [RANGE_W-1:0] rng;
        bit                 bs;
        logic [15:0]        e0;
        logic [15:0]        e1;
        logic [15:0]        e2;
        int                 nbytes;
        bit                 known;
        t_mg_set            res;
    } t_vec_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [RANGE_W-1:0] cfg_wdata;

    afsd_byte_if byte_ch();
    afsd_set_if  set_ch();

    accel_fifo_sample_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_byte      (byte_ch.sink),
        .o_set       (set_ch.source)
    );

    // predictor state
    logic [RANGE_W-1:0]      pr_range;
    int                      pr_phase;
    logic [BYTE_W-1:0]       pr_hi;
    logic signed [RAW_W-1:0] pr_x;
    logic signed [RAW_W-1:0] pr_y;
    bit                      pr_zero_seen;
    logic [COUNT_W-1:0]      pr_count;

    t_mg_set  pending_sets[$];
    t_vec_row vec_rows[$];

    int  errors;
    int  n_bytes;
    int  n_sets;
    int  n_invalid;
    int  burst_left;
    bit  gaps_on;
    bit  hold_req;
    int  idle_cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [RAW_W-1:0] scale_to_mg(logic [7:0] hi, logic [7:0] lo,
                                                           logic [RANGE_W-1:0] rng);
        logic signed [RAW_W-1:0] raw;
        int v;
        int mag;
        int sh;
        raw = {hi[5:0], lo};
        v = raw;
        case (rng)
            RANGE_4G: sh = 1;
            RANGE_8G: sh = 0;
            default:  sh = 2;
        endcase
        mag = (v < 0) ? -v : v;
        mag = mag >> sh;
        return RAW_W'((v < 0) ? -mag : mag);
    endfunction

    task automatic predict_byte(logic [7:0] b, logic bs);
        logic signed [RAW_W-1:0] z;
        t_mg_set s;
        if (bs) begin
            pr_phase = 0;
            pr_zero_seen = 0;
            pr_count = '0;
        end
        case (pr_phase)
            1: begin
                pr_x = scale_to_mg(pr_hi, b, pr_range);
                pr_phase = 2;
            end
            3: begin
                pr_y = scale_to_mg(pr_hi, b, pr_range);
                pr_phase = 4;
            end
            5: begin
                z = scale_to_mg(pr_hi, b, pr_range);
                pr_phase = 0;
                if (pr_x == 0 && pr_y == 0 && z == 0) pr_zero_seen = 1;
                if (!pr_zero_seen && pr_count < COUNT_MAX) pr_count = pr_count + 1'b1;
                s.x = pr_x;
                s.y = pr_y;
                s.z = z;
                s.ok = !pr_zero_seen;
                s.cnt = pr_count;
                pending_sets.push_back(s);
            end
            default: begin
                pr_hi = b;
                pr_phase = pr_phase + 1;
            end
        endcase
    endtask

    task automatic send_byte(logic [7:0] b, logic bs);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 99) < 15) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 4);
                if (gap > 0) begin
                    byte_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 48);
            end
            burst_left--;
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.fifo_byte   <= b;
        byte_ch.burst_start <= bs;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
        predict_byte(b, bs);
        n_bytes++;
    endtask

    task automatic send_entry(logic [15:0] e, logic bs);
        send_byte(e[15:8], bs);
        send_byte(e[7:0], 1'b0);
    endtask

    task automatic drain_sets();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_sets.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_range(logic [RANGE_W-1:0] v);
        drain_sets();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pr_range = v;
    endtask

    task automatic add_row(logic [RANGE_W-1:0] rng, bit bs, logic [15:0] e0, e1, e2,
                           int nbytes, bit known, int ex, ey, ez, bit ok, int cnt);
        t_vec_row r;
        r.rng = rng;
        r.bs = bs;
        r.e0 = e0;
        r.e1 = e1;
        r.e2 = e2;
        r.nbytes = nbytes;
        r.known = known;
        r.res.x = RAW_W'(ex);
        r.res.y = RAW_W'(ey);
        r.res.z = RAW_W'(ez);
        r.res.ok = ok;
        r.res.cnt = COUNT_W'(cnt);
        vec_rows.push_back(r);
    endtask

    task automatic run_vectors();
        t_vec_row r;
        logic [15:0] ent;
        for (int i = 0; i < vec_rows.size(); i++) begin
            r = vec_rows[i];
            if (r.rng != pr_range) write_range(r.rng);
            for (int k = 0; k < r.nbytes; k++) begin
                ent = (k < 2) ? r.e0 : (k < 4) ? r.e1 : r.e2;
                send_byte((k % 2 == 0) ? ent[15:8] : ent[7:0], r.bs && k == 0);
            end
            if (r.known && r.nbytes == 6) pending_sets[pending_sets.size() - 1] = r.res;
        end
    endtask

    function automatic logic [15:0] rand_entry(bit near_zero);
        logic [1:0] ch;
        logic [13:0] raw;
        int mode;
        ch = 2'($urandom);
        mode = near_zero ? 1 : $urandom_range(0, 9);
        case (mode)
            0: raw = '0;
            1, 2: raw = 14'(int'($urandom_range(0, 8)) - 4);
            3: begin
                case ($urandom_range(0, 3))
                    0: raw = 14'h1FFF;
                    1: raw = 14'h2000;
                    2: raw = 14'h3FFF;
                    default: raw = 14'h0000;
                endcase
            end
            default: raw = 14'($urandom);
        endcase
        return {ch, raw};
    endfunction

    task automatic random_phase(int target);
        int stop_at;
        int kind;
        int nsets;
        bit nz;
        stop_at = n_bytes + target;
        while (n_bytes < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                nsets = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                for (int s = 0; s < nsets; s++) begin
                    nz = ($urandom_range(0, 99) < 12);
                    send_entry(rand_entry(nz), s == 0);
                    send_entry(rand_entry(nz), 1'b0);
                    send_entry(rand_entry(nz), 1'b0);
                end
            end else if (kind < 90) begin
                send_byte(8'($urandom), 1'b1);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
        while (pr_phase != 0) send_byte(8'($urandom), 1'b0);
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int seg;
        int mode;
        int cyc;
        set_ch.ready <= 1'b0;
        seg = 0;
        mode = 0;
        cyc = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_req) begin
                set_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 0;
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(20, 200);
                    mode = $urandom_range(0, 3);
                end
                seg--;
                case (mode)
                    0: set_ch.ready <= 1'b1;
                    1: set_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: set_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: set_ch.ready <= (cyc % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_mg_set e;
        if (rst_n && set_ch.valid && set_ch.ready) begin
            n_sets++;
            if (pending_sets.size() == 0) begin
                $error("unexpected set x=%0d y=%0d z=%0d", set_ch.x_mg, set_ch.y_mg, set_ch.z_mg);
                errors++;
            end else begin
                e = pending_sets.pop_front();
                if (!e.ok) n_invalid++;
                if (set_ch.x_mg !== e.x) begin
                    $error("x_mg expected %0d actual %0d", e.x, set_ch.x_mg);
                    errors++;
                end
                if (set_ch.y_mg !== e.y) begin
                    $error("y_mg expected %0d actual %0d", e.y, set_ch.y_mg);
                    errors++;
                end
                if (set_ch.z_mg !== e.z) begin
                    $error("z_mg expected %0d actual %0d", e.z, set_ch.z_mg);
                    errors++;
                end
                if (set_ch.set_valid !== e.ok) begin
                    $error("set_valid expected %0d actual %0d", e.ok, set_ch.set_valid);
                    errors++;
                end
                if (set_ch.valid_sets !== e.cnt) begin
                    $error("valid_sets expected %0d actual %0d", e.cnt, set_ch.valid_sets);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (set_ch.valid && set_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        byte_ch.valid       <= 1'b0;
        byte_ch.fifo_byte   <= '0;
        byte_ch.burst_start <= 1'b0;
        idle_cycles = 0;
        errors = 0;
        n_bytes = 0;
        n_sets = 0;
        n_invalid = 0;
        burst_left = 0;
        gaps_on = 1;
        hold_req = 0;
        pr_range = RANGE_2G;
        pr_phase = 0;
        pr_hi = '0;
        pr_x = '0;
        pr_y = '0;
        pr_zero_seen = 0;
        pr_count = '0;

        // after reset, extremes, truncation, zero set, broken set, every range
        add_row(RANGE_2G, 1, 16'h0004, 16'h0008, 16'hFFFC, 6, 1, 1, 2, -1, 1, 1);
        add_row(RANGE_2G, 0, 16'h1FFF, 16'h2000, 16'hC001, 6, 1, 2047, -2048, 0, 1, 2);
        add_row(RANGE_2G, 0, 16'h0003, 16'h3FFF, 16'h0001, 6, 1, 0, 0, 0, 0, 2);
        add_row(RANGE_2G, 0, 16'h0100, 16'h0000, 16'h0000, 6, 1, 64, 0, 0, 0, 2);
        add_row(RANGE_2G, 1, 16'h0000, 16'h0000, 16'h0000, 6, 1, 0, 0, 0, 0, 0);
        add_row(RANGE_2G, 1, 16'h1234, 16'h5600, 16'h0000, 3, 0, 0, 0, 0, 0, 0);
        add_row(RANGE_4G, 1, 16'h1FFF, 16'h2000, 16'hBFFF, 6, 1, 4095, -4096, 0, 1, 1);
        add_row(RANGE_4G, 0, 16'h0001, 16'h0002, 16'h3FFE, 6, 1, 0, 1, -1, 1, 2);
        add_row(RANGE_8G, 1, 16'h1FFF, 16'h2000, 16'h7FFF, 6, 1, 8191, -8192, -1, 1, 1);
        add_row(RANGE_8G, 0, 16'h0000, 16'h0000, 16'h0001, 6, 1, 0, 0, 1, 1, 2);
        add_row(RANGE_UNUSED, 1, 16'h0004, 16'h2004, 16'h1234, 6, 1, 1, -2047, 1165, 1, 1);
        add_row(RANGE_UNUSED, 0, 16'hA5A5, 16'h5A5A, 16'hF0F0, 6, 0, 0, 0, 0, 0, 0);
        add_row(RANGE_2G, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6, 0, 0, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_vectors();

        write_range(RANGE_8G);
        random_phase(280);
        write_range(RANGE_2G);
        hold_req = 1;
        random_phase(280);
        write_range(RANGE_UNUSED);
        random_phase(140);
        drain_sets();
        random_phase(140);
        write_range(RANGE_4G);
        random_phase(280);
        write_range(RANGE_8G);
        random_phase(280);
        write_range(RANGE_2G);
        random_phase(280);

        drain_sets();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_sets.size() != 0) begin
            $error("%0d expected sets never arrived", pending_sets.size());
            errors++;
        end
        $display("Sent %0d bytes under all four range codes; checked %0d sets (%0d invalid).",
                 n_bytes, n_sets, n_invalid);
        $display("Covered zero-set marking, broken sets, bursty input, output back-pressure.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
